### src/sdm_pkg.sv
// shared types and constants of the sdram device model
`default_nettype none
package sdm_pkg;

	localparam int BANK_N = 4;

	// register indexes on the configuration port
	localparam logic [1:0] REG_POWER_UP_WAIT   = 2'd0;
	localparam logic [1:0] REG_REFRESH_LIMIT   = 2'd1;
	localparam logic [1:0] REG_BANK_OPEN_LIMIT = 2'd2;

	localparam logic [15:0] POWER_UP_WAIT_RST   = 16'd1000;
	localparam logic [23:0] REFRESH_LIMIT_RST   = 24'd65536;
	localparam logic [23:0] BANK_OPEN_LIMIT_RST = 24'd65536;

	// init sequence phases
	localparam logic [2:0] PH_WAIT   = 3'd0;
	localparam logic [2:0] PH_PRE    = 3'd1;
	localparam logic [2:0] PH_REF1   = 3'd2;
	localparam logic [2:0] PH_REF2   = 3'd3;
	localparam logic [2:0] PH_MODE   = 3'd4;
	localparam logic [2:0] PH_MRD    = 3'd5;
	localparam logic [2:0] PHASE_RUN = 3'd6;

	// timing waits
	localparam logic [15:0] T_RP  = 16'd3;
	localparam logic [15:0] T_RC  = 16'd9;
	localparam logic [15:0] T_MRD = 16'd2;
	localparam logic [15:0] T_WR  = 16'd2;

	localparam int           AP_BIT    = 10;
	localparam logic [12:0]  MODE_WORD = 13'h021;
	localparam logic [15:0]  LOW_BYTE  = 16'h00ff;
	localparam logic [15:0]  HIGH_BYTE = 16'hff00;

	// byte mask codes
	localparam logic [1:0] MASK_NONE = 2'd0;
	localparam logic [1:0] MASK_LOW  = 2'd1;
	localparam logic [1:0] MASK_HIGH = 2'd2;

	// error codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_REFRESH   = 3'd1;
	localparam logic [2:0] ERR_OPEN_LONG = 3'd2;
	localparam logic [2:0] ERR_BAD_CMD   = 3'd3;
	localparam logic [2:0] ERR_ACT_BUSY  = 3'd4;
	localparam logic [2:0] ERR_CLOSED    = 3'd5;
	localparam logic [2:0] ERR_INIT      = 3'd6;
	localparam logic [2:0] ERR_MODE      = 3'd7;

	typedef struct packed {
		logic [15:0] power_up_wait;
		logic [23:0] refresh_limit;
		logic [23:0] bank_open_limit;
		logic        wait_reload;
	} cfg_t;

endpackage
`default_nettype wire

### src/sdm_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none
module sdm_ram #(
	parameter int WIDTH = 16,
	parameter int AW    = 17,
	parameter int DEPTH = 131072
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/sdm_cfg.sv
// apb configuration registers
`default_nettype none
module sdm_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output sdm_pkg::cfg_t     cfg
);
	import sdm_pkg::*;

	logic [15:0] puw_q;
	logic [23:0] rlimit_q;
	logic [23:0] blimit_q;
	logic        reload;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			puw_q    <= POWER_UP_WAIT_RST;
			rlimit_q <= REFRESH_LIMIT_RST;
			blimit_q <= BANK_OPEN_LIMIT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_POWER_UP_WAIT:   puw_q    <= pwdata[15:0];
				REG_REFRESH_LIMIT:   rlimit_q <= pwdata[23:0];
				REG_BANK_OPEN_LIMIT: blimit_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// reload strobe for the init wait counter, same edge as the write
	assign reload = wr_en && (paddr[3:2] == REG_POWER_UP_WAIT);

	always_comb begin
		case (paddr[3:2])
			REG_POWER_UP_WAIT:   prdata = {16'd0, puw_q};
			REG_REFRESH_LIMIT:   prdata = {8'd0, rlimit_q};
			REG_BANK_OPEN_LIMIT: prdata = {8'd0, blimit_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg.power_up_wait   = puw_q;
	assign cfg.refresh_limit   = rlimit_q;
	assign cfg.bank_open_limit = blimit_q;
	assign cfg.wait_reload     = reload;
endmodule
`default_nettype wire

### src/sdram_device_model.sv
// sdram device model top level: command sequencer around storage and refresh memories
// latency: the accepting edge moves to evaluation, done is high in the following cycle
// sequence: a sample passes idle and evaluation, a write adds S_WR, a read adds S_RD0,
//   S_RD1, S_RD2; busy holds off new samples; storage ram takes one access per cycle
// reset: control state clears at once; storage is undefined until written and the
//   refresh deadline table is covered by a fill flag, so no clearing pass is needed
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none
module sdram_device_model #(
	parameter int ROW_BITS      = 6,
	parameter int REFRESH_SLOTS = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command request
	input  wire logic        start,
	output logic             busy,
	input  wire logic        chip_select_n,
	input  wire logic        row_strobe_n,
	input  wire logic        column_strobe_n,
	input  wire logic        write_enable_n,
	input  wire logic [1:0]  bank,
	input  wire logic [12:0] address,
	input  wire logic        drive,
	input  wire logic [15:0] write_data,
	input  wire logic [1:0]  byte_mask,
	// result
	output logic             done,
	output logic [15:0]      read_data,
	output logic             powered_up,
	output logic [2:0]       error_code,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sdm_pkg::*;

	localparam int AW       = ROW_BITS + 11;
	localparam int ST_DEPTH = 1 << AW;
	localparam int PW       = (REFRESH_SLOTS > 1) ? $clog2(REFRESH_SLOTS) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(REFRESH_SLOTS - 1);

	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WR, S_RD0, S_RD1, S_RD2} state_t;

	state_t state_q;
	cfg_t   cfg;

	// latched command sample
	logic        cs_q, ras_q, cas_q, we_q, drv_q;
	logic [1:0]  bk_q;
	logic [12:0] addr_q;
	logic [15:0] data_q;
	logic [1:0]  mask_q;

	// model state
	logic [2:0]    phase_q;
	logic [15:0]   wc_q;
	logic [31:0]   cc_q;
	logic [PW-1:0] ptr_q;
	logic          wrap_q;   // every deadline slot written since the init arm
	logic [31:0]   arm_q;    // deadline of slots not yet written since the arm
	logic          pend_q;
	logic [AW-1:0] ba_q;
	logic [AW-1:0] a_q;
	logic [2:0]    bp_q  [BANK_N];
	logic [23:0]   ot_q  [BANK_N];
	logic [12:0]   row_q [BANK_N];
	// read words queued for the bus, d1_q next out
	logic [15:0]   d1_q, d2_q, d3_q, d4_q;

	// next values from the evaluation step
	logic [2:0]    n_phase;
	logic [15:0]   n_wc, wc1;
	logic [31:0]   n_cc, n_arm, late;
	logic [PW-1:0] n_ptr;
	logic          n_wrap, n_pend;
	logic [AW-1:0] n_ba, cell_a;
	logic [2:0]    n_bp  [BANK_N];
	logic [23:0]   n_ot  [BANK_N];
	logic [12:0]   n_row [BANK_N];
	logic [15:0]   n_d1, n_d2, n_d3, n_d4, n_bus;
	logic [7:1]    ef;
	logic [2:0]    n_err;
	logic          merge_en, go_rd, go_wr;
	logic [15:0]   merged;

	// memory ports
	logic          st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [15:0]   st_wdata, st_rd;
	logic          dl_we;
	logic [31:0]   dl_wdata, dl_rd;

	logic sel, idle_cmd, cmd_ref, cmd_pre, cmd_act, cmd_mode, cmd_rw, accept;

	sdm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdm_ram #(.WIDTH(16), .AW(AW), .DEPTH(ST_DEPTH)) u_storage (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rd)
	);

	sdm_ram #(.WIDTH(32), .AW(PW), .DEPTH(REFRESH_SLOTS)) u_deadline (
		.clk   (clk),
		.we    (dl_we),
		.waddr (ptr_q),
		.wdata (dl_wdata),
		.raddr (ptr_q),
		.rdata (dl_rd)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// command decode on the latched sample
	assign sel      = !cs_q;
	assign idle_cmd = ras_q && cas_q && we_q;
	assign cmd_ref  = sel && !ras_q && !cas_q && we_q;
	assign cmd_pre  = sel && !ras_q && cas_q && !we_q;
	assign cmd_act  = sel && !ras_q && cas_q && we_q;
	assign cmd_mode = sel && !ras_q && !cas_q && !we_q;
	assign cmd_rw   = sel && ras_q && !cas_q;

	assign cell_a = {row_q[bk_q][ROW_BITS-1:0], bk_q, addr_q[8:0]};

	// second burst word merged under the byte mask
	always_comb begin
		case (mask_q)
			MASK_NONE: merged = data_q;
			MASK_LOW:  merged = (st_rd & LOW_BYTE) | (data_q & HIGH_BYTE);
			MASK_HIGH: merged = (st_rd & HIGH_BYTE) | (data_q & LOW_BYTE);
			default:   merged = st_rd;
		endcase
	end

	// one command bus sample
	always_comb begin
		n_phase  = phase_q;
		n_cc     = cc_q;
		n_arm    = arm_q;
		n_ptr    = ptr_q;
		n_wrap   = wrap_q;
		n_pend   = pend_q;
		n_ba     = ba_q;
		n_d1     = d1_q;
		n_d2     = d2_q;
		n_d3     = d3_q;
		n_d4     = d4_q;
		ef       = '0;
		merge_en = 1'b0;
		go_rd    = 1'b0;
		go_wr    = 1'b0;
		dl_we    = 1'b0;
		late     = '0;
		n_bus    = drv_q ? data_q : 16'd0;
		wc1      = (wc_q != 16'd0) ? wc_q - 16'd1 : wc_q;
		n_wc     = wc1;
		for (int i = 0; i < BANK_N; i++) begin
			n_bp[i]  = bp_q[i];
			n_ot[i]  = ot_q[i];
			n_row[i] = row_q[i];
		end
		if (phase_q < PHASE_RUN) begin
			n_pend = 1'b0;
			case (phase_q)
				PH_WAIT: begin
					if (!idle_cmd) ef[ERR_INIT] = 1'b1;
					if (wc1 == 16'd0) n_phase = PH_PRE;
				end
				PH_PRE: begin
					if (cmd_pre && addr_q[AP_BIT]) begin
						n_phase = PH_REF1;
						n_wc    = T_RP;
					end
				end
				PH_REF1, PH_REF2: begin
					if (wc1 == 16'd0) begin
						if (cmd_ref) begin
							n_phase = 3'(phase_q + 3'd1);
							n_wc    = T_RC;
							n_arm   = cc_q + {8'd0, cfg.refresh_limit};
							n_wrap  = 1'b0;
						end
					end else if (!idle_cmd) begin
						ef[ERR_INIT] = 1'b1;
					end
				end
				PH_MODE: begin
					if (wc1 == 16'd0) begin
						if (cmd_mode) begin
							if (addr_q == MODE_WORD) begin
								n_phase = PH_MRD;
								n_wc    = T_MRD;
							end else begin
								ef[ERR_MODE] = 1'b1;
							end
						end
					end else if (!idle_cmd) begin
						ef[ERR_INIT] = 1'b1;
					end
				end
				default: begin
					if (wc1 == 16'd0) n_phase = PHASE_RUN;
				end
			endcase
		end else begin
			n_cc = cc_q + 32'd1;
			late = n_cc - (wrap_q ? dl_rd : arm_q);
			if (late != 32'd0 && !late[31]) ef[ERR_REFRESH] = 1'b1;

			for (int i = 0; i < BANK_N; i++) begin
				n_bp[i] = bp_q[i] >> 1;
				if (n_bp[i][1]) n_bp[i][2] = 1'b1;
				if (n_bp[i][0]) begin
					if (ot_q[i] == 24'd0) ef[ERR_OPEN_LONG] = 1'b1;
					else n_ot[i] = ot_q[i] - 24'd1;
				end
			end

			if (wc1 != 16'd0 && pend_q) begin
				merge_en = 1'b1;
				n_ba     = AW'(ba_q + 1'b1);
				n_pend   = 1'b0;
			end

			n_bus = drv_q ? data_q : d1_q;
			n_d1  = d2_q;
			n_d2  = d3_q;
			n_d3  = d4_q;
			n_d4  = 16'd0;

			if (cmd_ref) begin
				// the deadline slot is written once, in the evaluation cycle
				dl_we = (state_q == S_EVAL);
				n_ptr = (ptr_q == PTR_LAST) ? '0 : PW'(ptr_q + 1'b1);
				if (ptr_q == PTR_LAST) n_wrap = 1'b1;
				for (int i = 0; i < BANK_N; i++) begin
					if (n_bp[i][2:1] != 2'd0) ef[ERR_BAD_CMD] = 1'b1;
				end
			end else if (cmd_pre) begin
				if (addr_q[AP_BIT]) begin
					for (int i = 0; i < BANK_N; i++) n_bp[i][2] = 1'b0;
				end else begin
					n_bp[bk_q][2] = 1'b0;
				end
			end else if (cmd_act) begin
				if (n_bp[bk_q] != 3'd0) ef[ERR_ACT_BUSY] = 1'b1;
				n_bp[bk_q][2] = 1'b1;
				n_ot[bk_q]    = cfg.bank_open_limit;
				n_row[bk_q]   = addr_q;
			end else if (cmd_rw) begin
				if (!n_bp[bk_q][0]) begin
					ef[ERR_CLOSED] = 1'b1;
				end else if (we_q == drv_q) begin
					ef[ERR_BAD_CMD] = 1'b1;
				end else begin
					if (!we_q) begin
						go_wr  = 1'b1;
						n_ba   = AW'(cell_a + 1'b1);
						n_pend = 1'b1;
					end else begin
						go_rd = 1'b1;
					end
					n_wc = T_WR;
					if (addr_q[AP_BIT]) begin
						n_bp[bk_q][2] = 1'b0;
						n_ot[bk_q]    = cfg.bank_open_limit;
					end
				end
			end else if (!sel || idle_cmd) begin
				// deselect or no-operation
			end else begin
				ef[ERR_BAD_CMD] = 1'b1;
			end
		end
		// lowest raised code wins
		n_err = ERR_OK;
		for (int k = 7; k >= 1; k--) begin
			if (ef[k]) n_err = 3'(k);
		end
	end

	assign dl_wdata = n_cc + {8'd0, cfg.refresh_limit};

	// storage port steering by sequencer step
	always_comb begin
		st_we    = 1'b0;
		st_waddr = ba_q;
		st_wdata = merged;
		case (state_q)
			S_EVAL: st_we = merge_en;
			S_WR: begin
				st_we    = 1'b1;
				st_waddr = a_q;
				st_wdata = data_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:  st_raddr = ba_q;
			S_RD1:   st_raddr = AW'(a_q + 1'b1);
			default: st_raddr = a_q;
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done       <= 1'b0;
			read_data  <= 16'd0;
			powered_up <= 1'b0;
			error_code <= ERR_OK;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EVAL;
				end
				S_EVAL: begin
					done       <= 1'b1;
					read_data  <= n_bus;
					powered_up <= (n_phase >= PHASE_RUN);
					error_code <= n_err;
					if (go_rd) state_q <= S_RD0;
					else if (go_wr) state_q <= S_WR;
					else state_q <= S_IDLE;
				end
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// captured command sample
	always_ff @(posedge clk) begin
		if (accept) begin
			cs_q   <= chip_select_n;
			ras_q  <= row_strobe_n;
			cas_q  <= column_strobe_n;
			we_q   <= write_enable_n;
			bk_q   <= bank;
			addr_q <= address;
			drv_q  <= drive;
			data_q <= write_data;
			mask_q <= byte_mask;
		end
	end

	// model state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			wc_q    <= POWER_UP_WAIT_RST;
			cc_q    <= '0;
			ptr_q   <= '0;
			wrap_q  <= 1'b0;
			arm_q   <= '0;
			pend_q  <= 1'b0;
			ba_q    <= '0;
			a_q     <= '0;
			d1_q    <= '0;
			d2_q    <= '0;
			d3_q    <= '0;
			d4_q    <= '0;
			for (int i = 0; i < BANK_N; i++) begin
				bp_q[i]  <= '0;
				ot_q[i]  <= '0;
				row_q[i] <= '0;
			end
		end else begin
			// the register takes the new value at this same edge
			if (cfg.wait_reload && phase_q == PH_WAIT) begin
				wc_q <= pwdata[15:0];
			end else if (state_q == S_EVAL) begin
				wc_q <= n_wc;
			end
			case (state_q)
				S_EVAL: begin
					phase_q <= n_phase;
					cc_q    <= n_cc;
					ptr_q   <= n_ptr;
					wrap_q  <= n_wrap;
					arm_q   <= n_arm;
					pend_q  <= n_pend;
					ba_q    <= n_ba;
					a_q     <= cell_a;
					d1_q    <= n_d1;
					d2_q    <= n_d2;
					d3_q    <= n_d3;
					d4_q    <= n_d4;
					for (int i = 0; i < BANK_N; i++) begin
						bp_q[i]  <= n_bp[i];
						ot_q[i]  <= n_ot[i];
						row_q[i] <= n_row[i];
					end
				end
				S_RD1:   d3_q <= st_rd;
				S_RD2:   d4_q <= st_rd;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an accepted request always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start the sequencer");

	// a write burst is only pending once the device is operational
	a_pend_run: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q >= PHASE_RUN))
		else $error("write burst pending during init");

	// init never falls back once complete
	a_run_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q >= PHASE_RUN) |=> (phase_q >= PHASE_RUN))
		else $error("left operational phase");
`endif
endmodule
`default_nettype wire
